### sv/assert_macros.svh
// Assertion macros shared by the sharpen filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clock edge, skipped while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that cond never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

### sv/rgbs_pkg.sv
// Shared types and constants of the 3x3 RGB sharpen filter.
package rgbs_pkg;

   localparam int MAX_DIM  = 1024;
   localparam int ADDR_W   = $clog2(MAX_DIM);
   localparam int SIZE_W   = ADDR_W + 1;
   localparam int CHAN_W   = 8;
   localparam int PIX_W    = 3 * CHAN_W;
   localparam int WIN_TAPS = 9;
   localparam int CENTER_TAP = 4;
   localparam int MIN_DIM  = 3;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } pixel_type;

   // Line store access for one cycle: read port and write port.
   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
   } ls_cmd_type;

   // Line store word: older row in the upper half, newer row in the lower half.
   typedef struct packed {
      pixel_type older;
      pixel_type newer;
   } ls_word_type;

endpackage

### sv/rgb_sharpen_3x3_clamped.sv
// Top level of the 3x3 RGB sharpen filter with clamped output.
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+------------------------------------
//   req     | in  | req_tvalid/req_tready | tdata: red, green, blue
//   rsp     | out | rsp_tvalid/rsp_tready | tdata: out_red/green/blue, tlast
//   csr     | in  | csr_tvalid/csr_tready | tdata: image_size (11 bits)
//
// One item per clock sustained while rsp_tready stays high; rsp_tvalid rises once its pixel has passed
// the input stage (pixel and line store read, loaded together) and then the result register.
// Border pixels produce no rsp item; interior results come out in raster order.
// Reset is synchronous, active high: image_size returns to 1024 and counters clear.
// A stalled rsp item holds; req keeps flowing until the input stage also fills.
// A csr write restarts the frame; write it only while the block is idle.
module rgb_sharpen_3x3_clamped (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] red, [15:8] green, [23:16] blue
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] out_red, [15:8] out_green, [23:16] out_blue
   output logic        rsp_tlast,   // last_of_image
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [15:0] csr_tdata    // [10:0] image_size, rest unused
);
   import rgbs_pkg::*;
   `include "assert_macros.svh"

   // Configuration and frame position
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [SIZE_W-1:0] size_eff;
   logic [ADDR_W-1:0] last_idx;
   logic [ADDR_W-1:0] row_ff, row_in;
   logic [ADDR_W-1:0] col_ff, col_in;

   // Input stage
   logic              valid_ff, valid_in;
   pixel_type         pix_ff;
   logic [ADDR_W-1:0] col_st_ff;
   logic              emit_ff;
   logic              last_ff;

   // Window: columns c-2 (entries 0..2) and c-1 (entries 3..5), rows top to bottom
   pixel_type         win_ff [6];

   // Result register
   logic              rsp_valid_ff, rsp_valid_in;
   pixel_type         rsp_pix_ff;
   logic              rsp_last_ff;

   logic              req_accept, csr_accept, advance;
   ls_cmd_type        ls_cmd;
   ls_word_type       ls_wr, ls_rd;
   pixel_type         win_pix [WIN_TAPS];
   pixel_type         sharp_pix;

   assign csr_tready = 1'b1;
   assign csr_accept = csr_tvalid && csr_tready;

   // Clamp the programmed size to the supported range
   always_comb begin
      if (size_ff < SIZE_W'(MIN_DIM)) begin
         size_eff = SIZE_W'(MIN_DIM);
      end else if (size_ff > SIZE_W'(MAX_DIM)) begin
         size_eff = SIZE_W'(MAX_DIM);
      end else begin
         size_eff = size_ff;
      end
   end
   assign last_idx = ADDR_W'(size_eff - SIZE_W'(1));

   // Advance the input stage when it holds no result or the result register can take it
   assign advance    = valid_ff && (!emit_ff || !rsp_valid_ff || rsp_tready);
   assign req_tready = !valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   // Frame position of the next pixel
   always_comb begin
      size_in = size_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      if (csr_accept) begin
         size_in = csr_tdata[SIZE_W-1:0];
         row_in  = '0;
         col_in  = '0;
      end else if (req_accept) begin
         if (col_ff == last_idx) begin
            col_in = '0;
            row_in = (row_ff == last_idx) ? '0 : row_ff + ADDR_W'(1);
         end else begin
            col_in = col_ff + ADDR_W'(1);
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (req_accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && emit_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= SIZE_W'(MAX_DIM);
         row_ff       <= '0;
         col_ff       <= '0;
         valid_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         size_ff      <= size_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the pixel and its position flags on accept
   always_ff @(posedge clock) begin
      if (req_accept) begin
         pix_ff    <= pixel_type'(req_tdata);
         col_st_ff <= col_ff;
         emit_ff   <= (row_ff >= ADDR_W'(2)) && (col_ff >= ADDR_W'(2));
         last_ff   <= (row_ff == last_idx) && (col_ff == last_idx);
      end
   end

   // Read the two rows above on accept; shift this column in when the stage advances
   assign ls_cmd.rd_en   = req_accept;
   assign ls_cmd.rd_addr = col_ff;
   assign ls_cmd.wr_en   = advance;
   assign ls_cmd.wr_addr = col_st_ff;
   assign ls_wr.older    = ls_rd.newer;
   assign ls_wr.newer    = pix_ff;

   rgbs_line_store u_line_store (
      .clock   (clock),
      .cmd     (ls_cmd),
      .wr_data (ls_wr),
      .rd_data (ls_rd)
   );

   // Slide the window one column when the stage advances
   always_ff @(posedge clock) begin
      if (advance) begin
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= ls_rd.older;
         win_ff[4] <= ls_rd.newer;
         win_ff[5] <= pix_ff;
      end
   end

   assign win_pix[0] = win_ff[0];
   assign win_pix[1] = win_ff[3];
   assign win_pix[2] = ls_rd.older;
   assign win_pix[3] = win_ff[1];
   assign win_pix[4] = win_ff[4];
   assign win_pix[5] = ls_rd.newer;
   assign win_pix[6] = win_ff[2];
   assign win_pix[7] = win_ff[5];
   assign win_pix[8] = pix_ff;

   rgbs_kernel u_kernel (
      .win_pix   (win_pix),
      .sharp_pix (sharp_pix)
   );

   // Load the result register with interior results only
   always_ff @(posedge clock) begin
      if (advance && emit_ff) begin
         rsp_pix_ff  <= sharp_pix;
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pix_ff;
   assign rsp_tlast  = rsp_last_ff;

   `ASSERT_CLK(a_col_in_frame, {1'b0, col_ff} < size_eff, "column counter outside frame")
   `ASSERT_CLK(a_row_in_frame, {1'b0, row_ff} < size_eff, "row counter outside frame")
   `ASSERT_NEVER(a_last_is_interior, valid_ff && last_ff && !emit_ff, "last flag on border pixel")
   `ASSERT_CLK(a_accept_fills, req_accept |=> valid_ff, "accepted item lost from input stage")

endmodule

### sv/rgbs_line_store.sv
// Dual line store: one memory holding the two rows above the current one.
module rgbs_line_store (
   input  logic                clock,
   input  rgbs_pkg::ls_cmd_type cmd,
   input  rgbs_pkg::ls_word_type wr_data,
   output rgbs_pkg::ls_word_type rd_data
);
   import rgbs_pkg::*;

   ls_word_type store_ff [MAX_DIM];
   ls_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         store_ff[cmd.wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= store_ff[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/rgbs_kernel.sv
// Sharpen kernel: 9 x center minus eight neighbors, clamped to 0..255 per channel.
module rgbs_kernel (
   input  rgbs_pkg::pixel_type win_pix [rgbs_pkg::WIN_TAPS],
   output rgbs_pkg::pixel_type sharp_pix
);
   import rgbs_pkg::*;

   localparam int ACC_W = CHAN_W + 4;

   function automatic logic [CHAN_W-1:0] sharpen_chan(
      input logic [CHAN_W-1:0] center,
      input logic [ACC_W-1:0]  ring_sum
   );
      logic [ACC_W-1:0] pos;
      logic [ACC_W-1:0] diff;
      logic [CHAN_W-1:0] res;
      pos  = ACC_W'(center) * ACC_W'(9);
      diff = pos - ring_sum;
      if (pos <= ring_sum) begin
         res = '0;
      end else if (diff > ACC_W'({CHAN_W{1'b1}})) begin
         res = {CHAN_W{1'b1}};
      end else begin
         res = diff[CHAN_W-1:0];
      end
      return res;
   endfunction

   logic [ACC_W-1:0] sum_r, sum_g, sum_b;

   // Sum the ring of eight neighbors, center excluded.
   always_comb begin
      sum_r = '0;
      sum_g = '0;
      sum_b = '0;
      for (int k = 0; k < WIN_TAPS; k++) begin
         if (k != CENTER_TAP) begin
            sum_r = sum_r + ACC_W'(win_pix[k].red);
            sum_g = sum_g + ACC_W'(win_pix[k].green);
            sum_b = sum_b + ACC_W'(win_pix[k].blue);
         end
      end
   end

   assign sharp_pix.red   = sharpen_chan(win_pix[CENTER_TAP].red, sum_r);
   assign sharp_pix.green = sharpen_chan(win_pix[CENTER_TAP].green, sum_g);
   assign sharp_pix.blue  = sharpen_chan(win_pix[CENTER_TAP].blue, sum_b);

endmodule
